// ===== rtl/delta_timer_queue_defines.svh =====
// ----------------------------------------------------------------------------
// delta_timer_queue_defines.svh
// Assertion macros used by the delta timer queue top level.
// ----------------------------------------------------------------------------
`ifndef DELTA_TIMER_QUEUE_DEFINES_SVH
`define DELTA_TIMER_QUEUE_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define DTQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define DTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dtq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg
// Types, codes and widths shared by the delta timer queue modules.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int HANDLE_BITS   = 8;
    localparam int DELAY_BITS    = 16;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_ZERO     = 3'd2,
        KIND_EXPIRED  = 3'd3,
        KIND_NONE     = 3'd4
    } kind_t;

    typedef struct packed {
        op_t                   opcode;
        logic [HANDLE_BITS-1:0] handle;
        logic [DELAY_BITS-1:0]  delay;
    } in_item_t;

    typedef struct packed {
        kind_t                  kind;
        logic [HANDLE_BITS-1:0] expired_handle;
        logic                   last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_CHECK,
        ST_WALK,
        ST_SHIFT_INIT,
        ST_SHIFT,
        ST_PLACE,
        ST_FIXUP,
        ST_ACK,
        ST_TICK_CHECK,
        ST_TICK_DEC,
        ST_TICK_NEXT
    } state_t;

    typedef struct packed {
        logic  load;
        logic  walk_start;
        logic  walk_step;
        logic  walk_stop;
        logic  shift_start;
        logic  shift_step;
        logic  place;
        logic  fixup;
        logic  rd_head;
        logic  dec_head;
        logic  pop;
        logic  emit;
        kind_t kind;
        logic  last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic delay_zero;
        logic full;
        logic empty;
        logic walk_adv;
        logic walk_last;
        logic shift_done;
        logic has_behind;
        logic head_live;
        logic next_exp;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/dtq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer for insert and tick operations on the delta timer list.
// ----------------------------------------------------------------------------
module dtq_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    input  wire dtq_pkg::op_t  s_opcode,
    output logic               s_ready,
    input  wire dtq_pkg::sts_t sts,
    output dtq_pkg::cmd_t      cmd
);

    dtq_pkg::state_t state_reg;
    dtq_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dtq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == dtq_pkg::ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = dtq_pkg::KIND_NONE;
        case (state_reg)
            dtq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_opcode == dtq_pkg::OP_INSERT) ?
                                 dtq_pkg::ST_INS_CHECK : dtq_pkg::ST_TICK_CHECK;
                end
            end
            dtq_pkg::ST_INS_CHECK: begin
                if (sts.delay_zero || sts.full) begin
                    if (sts.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.last   = 1'b1;
                        cmd.kind   = sts.delay_zero ? dtq_pkg::KIND_ZERO : dtq_pkg::KIND_FULL;
                        state_next = dtq_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.walk_start = 1'b1;
                    state_next     = sts.empty ? dtq_pkg::ST_SHIFT_INIT : dtq_pkg::ST_WALK;
                end
            end
            dtq_pkg::ST_WALK: begin
                if (sts.walk_adv) begin
                    cmd.walk_step = 1'b1;
                    state_next    = sts.walk_last ? dtq_pkg::ST_SHIFT_INIT : dtq_pkg::ST_WALK;
                end else begin
                    cmd.walk_stop = 1'b1;
                    state_next    = dtq_pkg::ST_SHIFT_INIT;
                end
            end
            dtq_pkg::ST_SHIFT_INIT: begin
                cmd.shift_start = 1'b1;
                state_next      = dtq_pkg::ST_SHIFT;
            end
            dtq_pkg::ST_SHIFT: begin
                if (sts.shift_done) begin
                    state_next = dtq_pkg::ST_PLACE;
                end else begin
                    cmd.shift_step = 1'b1;
                end
            end
            dtq_pkg::ST_PLACE: begin
                cmd.place  = 1'b1;
                state_next = sts.has_behind ? dtq_pkg::ST_FIXUP : dtq_pkg::ST_ACK;
            end
            dtq_pkg::ST_FIXUP: begin
                cmd.fixup  = 1'b1;
                state_next = dtq_pkg::ST_ACK;
            end
            dtq_pkg::ST_ACK: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.kind   = dtq_pkg::KIND_ACCEPTED;
                    state_next = dtq_pkg::ST_IDLE;
                end
            end
            dtq_pkg::ST_TICK_CHECK: begin
                if (sts.empty) begin
                    if (sts.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.last   = 1'b1;
                        cmd.kind   = dtq_pkg::KIND_NONE;
                        state_next = dtq_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.rd_head = 1'b1;
                    state_next  = dtq_pkg::ST_TICK_DEC;
                end
            end
            dtq_pkg::ST_TICK_DEC: begin
                if (sts.head_live) begin
                    if (sts.out_free) begin
                        cmd.dec_head = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.last     = 1'b1;
                        cmd.kind     = dtq_pkg::KIND_NONE;
                        state_next   = dtq_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = dtq_pkg::ST_TICK_NEXT;
                end
            end
            dtq_pkg::ST_TICK_NEXT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = dtq_pkg::KIND_EXPIRED;
                    if (sts.next_exp) begin
                        cmd.pop = 1'b1;
                    end else begin
                        cmd.last   = 1'b1;
                        state_next = dtq_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = dtq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/dtq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_datapath
// Ring-buffer list storage, walk and shift pointers, and the result register.
// ----------------------------------------------------------------------------
module dtq_datapath #(
    parameter int DEPTH = dtq_pkg::DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dtq_pkg::cmd_t     cmd,
    input  wire dtq_pkg::in_item_t s_item,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output dtq_pkg::out_item_t     m_item,
    output dtq_pkg::sts_t          sts
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DW    = dtq_pkg::DELAY_BITS;
    localparam int HW    = dtq_pkg::HANDLE_BITS;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    function automatic idx_t ptr_inc(input idx_t p);
        return (p == IDX_W'(DEPTH - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    function automatic idx_t ptr_dec(input idx_t p);
        return (p == '0) ? IDX_W'(DEPTH - 1) : p - IDX_W'(1);
    endfunction

    logic [DW-1:0] delta_mem [DEPTH];
    logic [HW-1:0] handle_mem [DEPTH];

    dtq_pkg::in_item_t  item_reg;
    dtq_pkg::out_item_t out_reg;
    logic               out_valid_reg;
    idx_t               head_reg, tail_reg, rd_ptr_reg, src_reg, wr_ptr_reg;
    cnt_t               count_reg, pos_reg, mv_reg;
    logic [DW-1:0]      sum_reg, behind_reg, rd_delta_reg;
    logic [HW-1:0]      rd_handle_reg, pend_h_reg;
    logic               has_behind_reg, wr_pend_reg;

    logic               rd_en;
    idx_t               rd_addr;
    logic               dw_en, hw_en;
    idx_t               dw_addr, hw_addr;
    logic [DW-1:0]      dw_data;
    logic [HW-1:0]      hw_data;
    logic [DW-1:0]      new_delta;
    logic [DW:0]        walk_sum;
    logic               out_free;

    assign new_delta = item_reg.delay - sum_reg;
    assign walk_sum  = {1'b0, sum_reg} + {1'b0, rd_delta_reg};
    assign out_free  = !out_valid_reg || m_ready;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = head_reg;
        if (cmd.walk_start || cmd.rd_head) begin
            rd_en   = 1'b1;
            rd_addr = head_reg;
        end else if (cmd.walk_step) begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc(rd_ptr_reg);
        end else if (cmd.pop) begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc(head_reg);
        end else if (cmd.shift_step && (mv_reg != '0)) begin
            rd_en   = 1'b1;
            rd_addr = src_reg;
        end
    end

    always_comb begin
        dw_en   = 1'b0;
        dw_addr = wr_ptr_reg;
        dw_data = rd_delta_reg;
        hw_en   = 1'b0;
        hw_addr = wr_ptr_reg;
        hw_data = rd_handle_reg;
        if (cmd.shift_step && wr_pend_reg) begin
            dw_en = 1'b1;
            hw_en = 1'b1;
        end else if (cmd.place) begin
            dw_en   = 1'b1;
            dw_addr = rd_ptr_reg;
            dw_data = new_delta;
            hw_en   = 1'b1;
            hw_addr = rd_ptr_reg;
            hw_data = item_reg.handle;
        end else if (cmd.fixup) begin
            dw_en   = 1'b1;
            dw_addr = ptr_inc(rd_ptr_reg);
            dw_data = behind_reg - new_delta;
        end else if (cmd.dec_head) begin
            dw_en   = 1'b1;
            dw_addr = head_reg;
            dw_data = rd_delta_reg - DW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (dw_en) begin
            delta_mem[dw_addr] <= dw_data;
        end
        if (hw_en) begin
            handle_mem[hw_addr] <= hw_data;
        end
        if (rd_en) begin
            rd_delta_reg  <= delta_mem[rd_addr];
            rd_handle_reg <= handle_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.place) begin
                tail_reg  <= ptr_inc(tail_reg);
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.pop) begin
                head_reg  <= ptr_inc(head_reg);
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.shift_start) begin
                wr_pend_reg <= 1'b0;
            end else if (cmd.shift_step) begin
                wr_pend_reg <= (mv_reg != '0);
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_item;
        end
        if (cmd.walk_start) begin
            sum_reg        <= '0;
            pos_reg        <= '0;
            rd_ptr_reg     <= head_reg;
            has_behind_reg <= 1'b0;
        end else if (cmd.walk_step) begin
            sum_reg    <= walk_sum[DW-1:0];
            pos_reg    <= pos_reg + CNT_W'(1);
            rd_ptr_reg <= ptr_inc(rd_ptr_reg);
        end else if (cmd.walk_stop) begin
            behind_reg     <= rd_delta_reg;
            has_behind_reg <= 1'b1;
        end
        if (cmd.shift_start) begin
            src_reg    <= ptr_dec(tail_reg);
            wr_ptr_reg <= tail_reg;
            mv_reg     <= count_reg - pos_reg;
        end else if (cmd.shift_step) begin
            if (mv_reg != '0) begin
                src_reg <= ptr_dec(src_reg);
                mv_reg  <= mv_reg - CNT_W'(1);
            end
            if (wr_pend_reg) begin
                wr_ptr_reg <= ptr_dec(wr_ptr_reg);
            end
        end
        if (cmd.pop) begin
            pend_h_reg <= rd_handle_reg;
        end
        if (cmd.emit) begin
            out_reg.kind           <= cmd.kind;
            out_reg.expired_handle <= (cmd.kind == dtq_pkg::KIND_EXPIRED) ? pend_h_reg : '0;
            out_reg.last           <= cmd.last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    always_comb begin
        sts            = '0;
        sts.out_free   = out_free;
        sts.delay_zero = (item_reg.delay == '0);
        sts.full       = (count_reg == CNT_W'(DEPTH));
        sts.empty      = (count_reg == '0);
        sts.walk_adv   = (walk_sum <= {1'b0, item_reg.delay});
        sts.walk_last  = ((pos_reg + CNT_W'(1)) == count_reg);
        sts.shift_done = (mv_reg == '0) && !wr_pend_reg;
        sts.has_behind = has_behind_reg;
        sts.head_live  = (rd_delta_reg > DW'(1));
        sts.next_exp   = (count_reg != '0) && (rd_delta_reg == '0);
    end

endmodule
`default_nettype wire

// ===== rtl/delta_timer_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// delta_timer_queue
// Delta-encoded timer list: insert waiters by delay, expire them on ticks.
// ----------------------------------------------------------------------------
// The list lives in a DEPTH-entry ring buffer with one read and one write
// port, so every operation is paced by that memory. An insert of a nonzero
// delay is checked, walks past the entries ahead of it, stops the walk,
// moves each entry behind the insertion point one place on, places the new
// entry, fixes the next delta when it lands ahead of an existing entry, and
// reports. A rejected insert, a tick on an empty list and a tick that
// expires nothing each report one result. A tick that expires K waiters
// presents K results, one each cycle while the receiver keeps up. A stalled
// receiver holds the operation at its next result. One item is in work at a
// time; a finished result waits in the output register while the next item
// is taken. Results hold the same order as the items that caused them.
// ----------------------------------------------------------------------------
`include "delta_timer_queue_defines.svh"

module delta_timer_queue #(
    parameter int DEPTH = dtq_pkg::DEPTH_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire dtq_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output dtq_pkg::out_item_t      m_item
);

    dtq_pkg::cmd_t cmd;
    dtq_pkg::sts_t sts;

    dtq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_item.opcode),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dtq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_item  (s_item),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item),
        .sts     (sts)
    );

    `DTQ_ASSERT_NEXT(a_busy_after_transfer, s_valid && s_ready, !s_ready, "ready after transfer")
    `DTQ_ASSERT_SAME(a_emit_into_free, cmd.emit, sts.out_free, "result register overwritten")
    `DTQ_ASSERT_SAME(a_idle_after_last, $past(aresetn) && $rose(s_ready), $past(cmd.emit && cmd.last), "idle without final result")

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delta timer queue.
// Inserts and ticks are driven through the input channel with bursty timing.
// A timer list model in the bench predicts every result, and each result is
// checked against it field by field while the receiver stalls on its own
// schedule. Covered: the reject paths, ordering on equal deadlines, a full
// list, multi-entry expiry, a long output stall and a random traffic mix.
// ----------------------------------------------------------------------------
module tb;
    import dtq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 2 * DEPTH + 16;
    localparam int RANDOM_ITEMS = 90;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    delta_timer_queue #(.DEPTH(DEPTH)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #10 aclk = ~aclk;

    // timer list model
    logic [DELAY_BITS-1:0]  list_delta [DEPTH];
    logic [HANDLE_BITS-1:0] list_handle [DEPTH];
    int                     list_count;
    out_item_t              due_outcomes[$];

    int items_sent;
    int results_seen;
    int mismatch_count;
    int accepted_count;
    int full_count;
    int zero_count;
    int expired_count;
    int max_expired;
    int idle_cycles;
    int burst_left;
    bit hold_req;
    int stall_mode;
    int mode_left;
    int stall_phase;

    function automatic void push_outcome(kind_t kind, logic [HANDLE_BITS-1:0] h,
                                         logic last);
        out_item_t o;
        o.kind           = kind;
        o.expired_handle = h;
        o.last           = last;
        due_outcomes.push_back(o);
    endfunction

    function automatic void advance_timer_list(in_item_t item);
        int unsigned            sum;
        int                     pos;
        int                     popped;
        logic [DELAY_BITS-1:0]  nd;
        if (item.opcode == OP_INSERT) begin
            if (item.delay == '0) begin
                push_outcome(KIND_ZERO, '0, 1'b1);
                zero_count++;
            end else if (list_count >= DEPTH) begin
                push_outcome(KIND_FULL, '0, 1'b1);
                full_count++;
            end else begin
                sum = 0;
                pos = 0;
                while (pos < list_count && sum + list_delta[pos] <= item.delay) begin
                    sum += list_delta[pos];
                    pos++;
                end
                for (int i = list_count; i > pos; i--) begin
                    list_delta[i]  = list_delta[i-1];
                    list_handle[i] = list_handle[i-1];
                end
                nd               = item.delay - sum[DELAY_BITS-1:0];
                list_delta[pos]  = nd;
                list_handle[pos] = item.handle;
                list_count++;
                if (pos + 1 < list_count) begin
                    list_delta[pos+1] -= nd;
                end
                push_outcome(KIND_ACCEPTED, '0, 1'b1);
                accepted_count++;
            end
        end else if (list_count == 0) begin
            push_outcome(KIND_NONE, '0, 1'b1);
        end else begin
            popped = 0;
            if (list_delta[0] != '0) begin
                list_delta[0]--;
            end
            while (list_count > 0 && list_delta[0] == '0) begin
                push_outcome(KIND_EXPIRED, list_handle[0], 1'b0);
                for (int i = 1; i < list_count; i++) begin
                    list_delta[i-1]  = list_delta[i];
                    list_handle[i-1] = list_handle[i];
                end
                list_count--;
                popped++;
            end
            if (popped == 0) begin
                push_outcome(KIND_NONE, '0, 1'b1);
            end else begin
                due_outcomes[due_outcomes.size()-1].last = 1'b1;
                expired_count += popped;
                if (popped > max_expired) begin
                    max_expired = popped;
                end
            end
        end
    endfunction

    function automatic in_item_t make_item(op_t op, int h, int d);
        in_item_t item;
        item.opcode = op;
        item.handle = h[HANDLE_BITS-1:0];
        item.delay  = d[DELAY_BITS-1:0];
        return item;
    endfunction

    function automatic void report(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] MISMATCH %s", $realtime, msg);
        end
    endfunction

    // check each result transfer against the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (due_outcomes.size() == 0) begin
                report($sformatf("unexpected result kind=%0d handle=%0d last=%0d",
                                 m_item.kind, m_item.expired_handle, m_item.last));
            end else begin
                want = due_outcomes.pop_front();
                if (m_item.kind !== want.kind
                        || m_item.expired_handle !== want.expired_handle
                        || m_item.last !== want.last) begin
                    report($sformatf({"result %0d: expected kind=%0d handle=%0d last=%0d,",
                                      " got kind=%0d handle=%0d last=%0d"},
                                     results_seen, want.kind, want.expired_handle,
                                     want.last, m_item.kind, m_item.expired_handle,
                                     m_item.last));
                end
            end
        end
    end

    // watchdog on transfer activity
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d cycles without a transfer", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // receiver: switches between random stall patterns, with an optional long hold
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(20, 80);
                end
                mode_left--;
                stall_phase++;
                case (stall_mode)
                    0: begin
                        m_ready = 1'b1;
                    end
                    1: begin
                        m_ready = ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        m_ready = ((stall_phase % 5) < 3);
                    end
                    default: begin
                        m_ready = ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_item(input in_item_t item, input bit allow_gap);
        int gap;
        s_item  = item;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        advance_timer_list(item);
        items_sent++;
        @(negedge aclk);
        if (allow_gap) begin
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                if (gap > 0) begin
                    s_valid = 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
        end
    endtask

    task automatic wait_for_drain();
        s_valid = 1'b0;
        while (due_outcomes.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_empty_list();
        send_item(make_item(OP_TICK, 0, 0), 1'b1);
        send_item(make_item(OP_INSERT, 255, 0), 1'b1);
    endtask

    task automatic test_insert_order();
        send_item(make_item(OP_INSERT, 255, 1), 1'b1);
        send_item(make_item(OP_INSERT, 0, 65535), 1'b1);
        send_item(make_item(OP_INSERT, 'h5a, 1), 1'b1);
        send_item(make_item(OP_TICK, 'hff, 'hffff), 1'b1);
    endtask

    task automatic test_full_list();
        int fill;
        fill = DEPTH - list_count;
        repeat (fill) begin
            send_item(make_item(OP_INSERT, $urandom_range(0, 255), 2), 1'b1);
        end
        send_item(make_item(OP_INSERT, 'ha5, 3), 1'b1);
        send_item(make_item(OP_INSERT, 'h3c, 0), 1'b1);
        send_item(make_item(OP_TICK, 0, 0), 1'b1);
        send_item(make_item(OP_TICK, 0, 0), 1'b1);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (12) begin
            if ($urandom_range(0, 2) == 0) begin
                send_item(make_item(OP_TICK, $urandom, $urandom), 1'b0);
            end else begin
                send_item(make_item(OP_INSERT, $urandom_range(0, 255),
                                    $urandom_range(1, 5)), 1'b0);
            end
        end
        wait_for_drain();
    endtask

    function automatic in_item_t random_item();
        int r;
        int d;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return make_item(OP_TICK, $urandom, $urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            d = $urandom_range(1, 6);
        end else if (r < 82) begin
            d = $urandom_range(7, 40);
        end else if (r < 94) begin
            d = $urandom_range(1, 65535);
        end else begin
            d = 0;
        end
        return make_item(OP_INSERT, $urandom_range(0, 255), d);
    endfunction

    task automatic test_random_traffic();
        int sent;
        int d;
        int k;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                // cluster of equal deadlines, then tick them out
                d = $urandom_range(1, 4);
                k = $urandom_range(2, 6);
                repeat (k) begin
                    send_item(make_item(OP_INSERT, $urandom_range(0, 255), d), 1'b1);
                end
                repeat (d) begin
                    send_item(make_item(OP_TICK, $urandom, $urandom), 1'b1);
                end
                sent += k + d;
            end else begin
                send_item(random_item(), 1'b1);
                sent++;
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_item     = '0;
        list_count = 0;
        burst_left = $urandom_range(1, 12);
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        test_empty_list();
        test_insert_order();
        test_full_list();
        test_backpressure();
        test_random_traffic();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d items, checked %0d results, %0d mismatches",
                 items_sent, results_seen, mismatch_count);
        $display("Inserts accepted %0d, full %0d, zero %0d; expired %0d, max %0d per tick",
                 accepted_count, full_count, zero_count, expired_count, max_expired);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
